// ===== hdl/i2cbm_pkg.sv =====
// Package for the byte-level I2C master.
// Holds the command codes, the timer width, the configuration and result types.
// Used by every file in hdl/.
package i2cbm_pkg;

  localparam int TIMER_W   = 16;
  localparam int UNIT_W    = 16;
  localparam int PHASE_W   = 5;
  localparam int OUT_DW    = 16;
  localparam int IN_DW     = 16;
  localparam int CFG_IW    = 2;
  localparam int CFG_DW    = 16;

  typedef enum logic [2:0] {
    OP_IDLE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NAK   = 3'd6,
    OP_RSVD  = 3'd7
  } op_t;

  typedef enum logic [CFG_IW-1:0] {
    REG_UNIT_TICKS  = 2'd0,
    REG_START_STOP  = 2'd1,
    REG_ACK_POLL    = 2'd2,
    REG_NONE        = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic [UNIT_W-1:0]  unit_ticks;
    logic [3:0]         start_stop_units;
    logic [7:0]         ack_poll_limit;
  } cfg_t;

  // Packed so that the last field lands in bit 0.
  typedef struct packed {
    logic       pad;
    logic       cmd_done;
    logic       slave_acked;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       busy_res;
    logic       sda_drive;
    logic       sda_level;
    logic       scl_level;
  } res_t;

endpackage

// ===== hdl/i2c_byte_master.sv =====
// Top level of the byte-level I2C master: request and result streams, register port.
// Instantiates i2cbm_core and i2cbm_skid; depends on i2cbm_pkg.
//
// Usage:
//   in_*   request stream. in_tuser is the command (tick, start, stop, write,
//          read, ack, nak); in_tdata carries the write byte and the SDA sample.
//          Every request, ticks included, advances the bus timing by one tick.
//   out_*  result stream, one result per request: pin levels, busy, last read
//          byte, read and command completion strobes, slave acknowledge.
//   cfg_*  register writes (unit ticks, start/stop hold units, ack poll limit);
//          always ready, write only while the stream is idle.
// Output: each result is registered in i2cbm_skid before it appears on out_*.
// Throughput: one request per cycle while in_tready is high; single-pass sequencer.
// Reset: bus released with SCL and SDA high, sequencer idle, registers at
//   their defaults, both streams empty.
// Stall: a skid stage holds one more result while out_tready is low, after
//   which in_tready drops until the receiver takes a result.
module i2c_byte_master (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [i2cbm_pkg::IN_DW-1:0]     in_tdata,   // wr_byte[7:0], sda_sample[8]
  input  logic [2:0]                      in_tuser,   // cmd[2:0]
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [i2cbm_pkg::OUT_DW-1:0]    out_tdata,  // scl_level, sda_level, sda_drive,
                                                      // busy_res, read_byte[7:0],
                                                      // read_valid, slave_acked, cmd_done
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [i2cbm_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [i2cbm_pkg::CFG_DW-1:0]    cfg_data
);

  i2cbm_pkg::cfg_t cfg_r;
  i2cbm_pkg::res_t res;
  i2cbm_pkg::res_t out_res;
  logic            acc;

  assign cfg_ready = 1'b1;
  assign acc       = in_tvalid && in_tready;
  assign out_tdata = i2cbm_pkg::OUT_DW'(out_res);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.unit_ticks       <= i2cbm_pkg::UNIT_W'(5);
      cfg_r.start_stop_units <= 4'd3;
      cfg_r.ack_poll_limit   <= 8'd50;
    end else if (cfg_valid && cfg_ready) begin
      unique case (i2cbm_pkg::reg_idx_t'(cfg_index))
        i2cbm_pkg::REG_UNIT_TICKS: cfg_r.unit_ticks       <= cfg_data[i2cbm_pkg::UNIT_W-1:0];
        i2cbm_pkg::REG_START_STOP: cfg_r.start_stop_units <= cfg_data[3:0];
        i2cbm_pkg::REG_ACK_POLL:   cfg_r.ack_poll_limit   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  i2cbm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .acc        (acc),
    .cmd        (in_tuser),
    .wr_byte    (in_tdata[7:0]),
    .sda_sample (in_tdata[8]),
    .cfg        (cfg_r),
    .res        (res)
  );

  i2cbm_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (acc),
    .res       (res),
    .res_ready (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

endmodule

// ===== hdl/i2cbm_core.sv =====
// Command sequencer of the byte-level I2C master: pin state, timers, shifter.
// Computes one result per accepted request in a single pass.
// Depends on i2cbm_pkg.
module i2cbm_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                acc,
  input  logic [2:0]          cmd,
  input  logic [7:0]          wr_byte,
  input  logic                sda_sample,
  input  i2cbm_pkg::cfg_t     cfg,
  output i2cbm_pkg::res_t     res
);

  localparam logic [63:0] TMAX64 = (64'd1 << i2cbm_pkg::TIMER_W) - 64'd1;

  i2cbm_pkg::op_t                 op_r, op_nxt;
  logic [i2cbm_pkg::PHASE_W-1:0]  ph_r, ph_nxt;
  logic [3:0]                     bi_r, bi_nxt;
  logic [7:0]                     sh_r, sh_nxt;
  logic [i2cbm_pkg::TIMER_W-1:0]  tm_r, tm_nxt;
  logic [7:0]                     pc_r, pc_nxt;
  logic                           scl_r, scl_nxt;
  logic                           sda_r, sda_nxt;
  logic                           oe_r, oe_nxt;
  logic                           ack_r, ack_nxt;
  logic [7:0]                     rd_r, rd_nxt;

  logic [i2cbm_pkg::PHASE_W-1:0]  p;
  logic [i2cbm_pkg::UNIT_W-1:0]   u_sat;
  logic [i2cbm_pkg::TIMER_W-1:0]  eff;
  logic [i2cbm_pkg::TIMER_W-1:0]  tm_dec;
  logic [3:0]                     hold;
  logic [3:0]                     bi_inc;
  logic                           act_en;
  logic                           cmd_ok;
  logic                           done;
  logic                           rnow;

  assign u_sat = (64'(cfg.unit_ticks) > TMAX64) ? i2cbm_pkg::UNIT_W'(TMAX64) : cfg.unit_ticks;
  assign eff  = (cfg.unit_ticks == '0) ? i2cbm_pkg::TIMER_W'(1) : i2cbm_pkg::TIMER_W'(u_sat);
  assign hold = (cfg.start_stop_units == 4'd0) ? 4'd0 : cfg.start_stop_units - 4'd1;
  assign cmd_ok = (cmd >= 3'(i2cbm_pkg::OP_START)) && (cmd <= 3'(i2cbm_pkg::OP_NAK));

  always_comb begin
    op_nxt  = op_r;
    ph_nxt  = ph_r;
    bi_nxt  = bi_r;
    sh_nxt  = sh_r;
    tm_nxt  = tm_r;
    pc_nxt  = pc_r;
    scl_nxt = scl_r;
    sda_nxt = sda_r;
    oe_nxt  = oe_r;
    ack_nxt = ack_r;
    rd_nxt  = rd_r;
    act_en  = 1'b0;
    done    = 1'b0;
    rnow    = 1'b0;
    p       = '0;
    bi_inc  = '0;
    tm_dec  = (tm_r != '0) ? tm_r - i2cbm_pkg::TIMER_W'(1) : tm_r;

    if (op_r == i2cbm_pkg::OP_IDLE) begin
      if (cmd_ok) begin
        op_nxt = i2cbm_pkg::op_t'(cmd);
        ph_nxt = '0;
        bi_nxt = '0;
        pc_nxt = '0;
        if (op_nxt == i2cbm_pkg::OP_WRITE) sh_nxt = wr_byte;
        if (op_nxt == i2cbm_pkg::OP_READ)  sh_nxt = '0;
        act_en = 1'b1;
      end
    end else begin
      tm_nxt = tm_dec;
      if (tm_dec == '0) begin
        if ((op_r == i2cbm_pkg::OP_START || op_r == i2cbm_pkg::OP_STOP) && bi_r != 4'd0) begin
          bi_nxt = bi_r - 4'd1;
          tm_nxt = eff;
        end else begin
          act_en = 1'b1;
        end
      end
    end

    if (act_en) begin
      p      = ph_nxt;
      ph_nxt = p + 5'd1;
      bi_inc = bi_nxt + 4'd1;
      unique case (op_nxt)
        i2cbm_pkg::OP_START: begin
          if (p == 5'd0) begin
            oe_nxt = 1'b1; sda_nxt = 1'b1; scl_nxt = 1'b1; tm_nxt = eff; bi_nxt = hold;
          end else if (p == 5'd1) begin
            sda_nxt = 1'b0; tm_nxt = eff; bi_nxt = hold;
          end else if (p == 5'd2) begin
            scl_nxt = 1'b0; tm_nxt = eff; bi_nxt = hold;
          end else begin
            done = 1'b1;
          end
        end
        i2cbm_pkg::OP_STOP: begin
          if (p == 5'd0) begin
            oe_nxt = 1'b1; sda_nxt = 1'b0; scl_nxt = 1'b1; tm_nxt = eff; bi_nxt = hold;
          end else if (p == 5'd1) begin
            sda_nxt = 1'b1; tm_nxt = eff; bi_nxt = hold;
          end else begin
            oe_nxt = 1'b0; done = 1'b1;
          end
        end
        i2cbm_pkg::OP_ACK, i2cbm_pkg::OP_NAK: begin
          if (p == 5'd0) begin
            oe_nxt = 1'b1; sda_nxt = (op_nxt == i2cbm_pkg::OP_NAK); tm_nxt = eff;
          end else if (p == 5'd1) begin
            scl_nxt = 1'b1; tm_nxt = eff;
          end else if (p == 5'd2) begin
            scl_nxt = 1'b0; tm_nxt = eff;
          end else begin
            done = 1'b1;
          end
        end
        i2cbm_pkg::OP_WRITE: begin
          if (p == 5'd0) begin
            oe_nxt = 1'b1; sda_nxt = sh_nxt[7]; sh_nxt = {sh_nxt[6:0], 1'b0}; tm_nxt = eff;
          end else if (p == 5'd1) begin
            scl_nxt = 1'b1; tm_nxt = eff;
          end else if (p == 5'd2) begin
            scl_nxt = 1'b0; tm_nxt = eff; bi_nxt = bi_inc;
            ph_nxt = (bi_inc < 4'd8) ? 5'd0 : 5'd3;
          end else if (p == 5'd3) begin
            oe_nxt = 1'b0; sda_nxt = 1'b1; tm_nxt = eff;
          end else if (p == 5'd4) begin
            scl_nxt = 1'b1; pc_nxt = '0; tm_nxt = eff;
          end else if (p == 5'd5) begin
            if (pc_nxt < cfg.ack_poll_limit && !sda_sample) begin
              ack_nxt = 1'b1; scl_nxt = 1'b0; tm_nxt = eff;
            end else if (pc_nxt >= cfg.ack_poll_limit) begin
              ack_nxt = 1'b0; scl_nxt = 1'b0; tm_nxt = eff;
            end else begin
              pc_nxt = pc_nxt + 8'd1; tm_nxt = eff; ph_nxt = 5'd5;
            end
          end else begin
            oe_nxt = 1'b1; done = 1'b1;
          end
        end
        i2cbm_pkg::OP_READ: begin
          if (p == 5'd0) begin
            oe_nxt = 1'b0; tm_nxt = eff;
          end else if (p == 5'd1) begin
            scl_nxt = 1'b1; sh_nxt = {sh_nxt[6:0], sda_sample}; tm_nxt = eff;
          end else if (p == 5'd2) begin
            scl_nxt = 1'b0; tm_nxt = eff; bi_nxt = bi_inc;
            ph_nxt = (bi_inc < 4'd8) ? 5'd0 : 5'd3;
          end else begin
            rd_nxt = sh_nxt; rnow = 1'b1; done = 1'b1;
          end
        end
        default: begin
          done = 1'b1;
        end
      endcase
      if (done) begin
        op_nxt = i2cbm_pkg::OP_IDLE;
        ph_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r  <= i2cbm_pkg::OP_IDLE;
      ph_r  <= '0;
      bi_r  <= '0;
      sh_r  <= '0;
      tm_r  <= '0;
      pc_r  <= '0;
      scl_r <= 1'b1;
      sda_r <= 1'b1;
      oe_r  <= 1'b0;
      ack_r <= 1'b0;
      rd_r  <= '0;
    end else if (acc) begin
      op_r  <= op_nxt;
      ph_r  <= ph_nxt;
      bi_r  <= bi_nxt;
      sh_r  <= sh_nxt;
      tm_r  <= tm_nxt;
      pc_r  <= pc_nxt;
      scl_r <= scl_nxt;
      sda_r <= sda_nxt;
      oe_r  <= oe_nxt;
      ack_r <= ack_nxt;
      rd_r  <= rd_nxt;
    end
  end

  always_comb begin
    res             = '0;
    res.scl_level   = scl_nxt;
    res.sda_level   = sda_nxt;
    res.sda_drive   = oe_nxt;
    res.busy_res    = (op_nxt != i2cbm_pkg::OP_IDLE);
    res.read_byte   = rd_nxt;
    res.read_valid  = rnow;
    res.slave_acked = ack_nxt;
    res.cmd_done    = done;
  end

endmodule

// ===== hdl/i2cbm_skid.sv =====
// Output register with a skid stage for the I2C master result stream.
// Takes a new result while the previous one waits on a stalled receiver.
// Depends on i2cbm_pkg.
module i2cbm_skid (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_valid,
  input  i2cbm_pkg::res_t  res,
  output logic             res_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output i2cbm_pkg::res_t  out_res
);

  logic            main_vld_r;
  logic            skid_vld_r;
  i2cbm_pkg::res_t main_r;
  i2cbm_pkg::res_t skid_r;

  assign res_ready = !skid_vld_r;
  assign out_valid = main_vld_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!main_vld_r || out_ready) begin
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= res_valid;
      end
    end else if (res_valid && res_ready) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!main_vld_r || out_ready) begin
      main_r <= skid_vld_r ? skid_r : res;
    end else if (res_valid && res_ready) begin
      skid_r <= res;
    end
  end

endmodule

// ===== hdl/i2cbm_checker.sv =====
// Port-level checks for the byte-level I2C master, bound to the top level.
// Depends on i2cbm_pkg and the ports of i2c_byte_master.
module i2cbm_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tready,
  input  logic                          out_tvalid,
  input  logic                          out_tready,
  input  logic [i2cbm_pkg::OUT_DW-1:0]  out_tdata
);

  i2cbm_pkg::res_t r;
  assign r = i2cbm_pkg::res_t'(out_tdata);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.cmd_done |-> !r.busy_res)
    else $error("completion reported while busy");

  a_read_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && r.read_valid |-> r.cmd_done)
    else $error("read strobe without completion");

  a_stall_only: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid && $past(out_tvalid && !out_tready))
    else $error("request side stalled without a held result");

endmodule

bind i2c_byte_master i2cbm_checker u_chk (.*);

// ===== sim/testbench.sv =====
// Self-checking bench for i2c_byte_master: a directed table, then random I2C frames and noise.
// Results are compared against a cycle-accurate model of the SCL/SDA sequencer kept here.
// Depends on hdl/i2cbm_pkg.sv and hdl/i2c_byte_master.sv.
`timescale 1ns / 100ps

module testbench;

  typedef enum logic [1:0] {
    SDA_LOW      = 2'd0,
    SDA_HIGH     = 2'd1,
    SDA_RAND     = 2'd2,
    SDA_RARE_LOW = 2'd3
  } sda_mode_t;

  typedef struct packed {
    logic                  is_cfg;
    i2cbm_pkg::op_t        op;
    i2cbm_pkg::reg_idx_t   ri;
    logic [15:0]           val;
    sda_mode_t             sdm;
    logic                  fixed;
    logic [15:0]           fixed_word;
  } plan_row_t;

  localparam int N_PLAN = 27;
  localparam int N_PHASES = 8;
  localparam int N_ITEMS = 1700;

  // First item of a row is typed in where fixed is set.
  localparam plan_row_t PLAN [N_PLAN] = '{
    '{1'b0, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_NONE,       16'h0000, SDA_HIGH,     1'b1,
      16'h0003},
    '{1'b0, i2cbm_pkg::OP_RSVD,  i2cbm_pkg::REG_NONE,       16'h00FF, SDA_LOW,      1'b1,
      16'h0003},
    '{1'b0, i2cbm_pkg::OP_START, i2cbm_pkg::REG_NONE,       16'h0000, SDA_HIGH,     1'b1,
      16'h000F},
    '{1'b0, i2cbm_pkg::OP_WRITE, i2cbm_pkg::REG_NONE,       16'h00A5, SDA_LOW,      1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_UNIT_TICKS, 16'h0001, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_WRITE, i2cbm_pkg::REG_NONE,       16'h005A, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_READ,  i2cbm_pkg::REG_NONE,       16'h0000, SDA_RAND,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_ACK,   i2cbm_pkg::REG_NONE,       16'h0000, SDA_RAND,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_READ,  i2cbm_pkg::REG_NONE,       16'h0000, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_NAK,   i2cbm_pkg::REG_NONE,       16'h0000, SDA_RAND,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_READ,  i2cbm_pkg::REG_NONE,       16'h0000, SDA_LOW,      1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_STOP,  i2cbm_pkg::REG_NONE,       16'h0000, SDA_RAND,     1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_ACK_POLL,   16'h0000, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_WRITE, i2cbm_pkg::REG_NONE,       16'h00FF, SDA_LOW,      1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_ACK_POLL,   16'h00FF, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_WRITE, i2cbm_pkg::REG_NONE,       16'h0000, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_WRITE, i2cbm_pkg::REG_NONE,       16'h0081, SDA_RARE_LOW, 1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_START_STOP, 16'h0000, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_START, i2cbm_pkg::REG_NONE,       16'h0000, SDA_RAND,     1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_START_STOP, 16'h000F, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_STOP,  i2cbm_pkg::REG_NONE,       16'h0000, SDA_RAND,     1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_UNIT_TICKS, 16'h0000, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_WRITE, i2cbm_pkg::REG_NONE,       16'h003C, SDA_RAND,     1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_NONE,       16'hBEEF, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_START_STOP, 16'h0001, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b1, i2cbm_pkg::OP_IDLE,  i2cbm_pkg::REG_UNIT_TICKS, 16'h0002, SDA_HIGH,     1'b0,
      16'h0000},
    '{1'b0, i2cbm_pkg::OP_STOP,  i2cbm_pkg::REG_NONE,       16'h0000, SDA_RAND,     1'b0,
      16'h0000}
  };

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_tvalid = 1'b0;
  logic                          in_tready;
  logic [i2cbm_pkg::IN_DW-1:0]   in_tdata = '0;
  logic [2:0]                    in_tuser = '0;
  logic                          out_tvalid;
  logic                          out_tready = 1'b0;
  logic [i2cbm_pkg::OUT_DW-1:0]  out_tdata;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  i2cbm_pkg::reg_idx_t           cfg_index = i2cbm_pkg::REG_UNIT_TICKS;
  logic [i2cbm_pkg::CFG_DW-1:0]  cfg_data = '0;

  i2c_byte_master dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // Sequencer model state
  i2cbm_pkg::cfg_t  bus_cfg;
  i2cbm_pkg::op_t   bus_op;
  logic [4:0]       bus_phase;
  logic [3:0]       bus_bits;
  logic [7:0]       bus_shift;
  logic [15:0]      bus_timer;
  logic [7:0]       bus_polls;
  logic             scl_q, sda_q, oe_q, ack_q;
  logic [7:0]       rd_hold;
  logic             done_q, rdv_q;

  i2cbm_pkg::res_t  pin_results_q[$];
  int               n_req, n_res, n_bad, n_cfg, n_done, n_reads, n_acked;
  int               burst_left;
  logic             noisy;
  logic             fixed_pending;
  logic [15:0]      fixed_word;

  function automatic logic [15:0] unit_len();
    return (bus_cfg.unit_ticks == '0) ? 16'd1 : bus_cfg.unit_ticks;
  endfunction

  function automatic void start_hold();
    bus_timer = unit_len();
    bus_bits = (bus_cfg.start_stop_units == 4'd0) ? 4'd0 : bus_cfg.start_stop_units - 4'd1;
  endfunction

  function automatic void seq_finish();
    bus_op = i2cbm_pkg::OP_IDLE;
    bus_phase = '0;
    done_q = 1'b1;
  endfunction

  function automatic void bus_act(input logic sd);
    logic [4:0] p;
    p = bus_phase;
    bus_phase = p + 5'd1;
    case (bus_op)
      i2cbm_pkg::OP_START: begin
        if (p == 5'd0) begin
          oe_q = 1'b1; sda_q = 1'b1; scl_q = 1'b1; start_hold();
        end else if (p == 5'd1) begin
          sda_q = 1'b0; start_hold();
        end else if (p == 5'd2) begin
          scl_q = 1'b0; start_hold();
        end else begin
          seq_finish();
        end
      end
      i2cbm_pkg::OP_STOP: begin
        if (p == 5'd0) begin
          oe_q = 1'b1; sda_q = 1'b0; scl_q = 1'b1; start_hold();
        end else if (p == 5'd1) begin
          sda_q = 1'b1; start_hold();
        end else begin
          oe_q = 1'b0; seq_finish();
        end
      end
      i2cbm_pkg::OP_ACK, i2cbm_pkg::OP_NAK: begin
        if (p == 5'd0) begin
          oe_q = 1'b1; sda_q = (bus_op == i2cbm_pkg::OP_NAK); bus_timer = unit_len();
        end else if (p == 5'd1) begin
          scl_q = 1'b1; bus_timer = unit_len();
        end else if (p == 5'd2) begin
          scl_q = 1'b0; bus_timer = unit_len();
        end else begin
          seq_finish();
        end
      end
      i2cbm_pkg::OP_WRITE: begin
        if (p == 5'd0) begin
          oe_q = 1'b1; sda_q = bus_shift[7]; bus_shift = bus_shift << 1;
          bus_timer = unit_len();
        end else if (p == 5'd1) begin
          scl_q = 1'b1; bus_timer = unit_len();
        end else if (p == 5'd2) begin
          scl_q = 1'b0; bus_timer = unit_len();
          bus_bits = bus_bits + 4'd1;
          bus_phase = (bus_bits < 4'd8) ? 5'd0 : 5'd3;
        end else if (p == 5'd3) begin
          oe_q = 1'b0; sda_q = 1'b1; bus_timer = unit_len();
        end else if (p == 5'd4) begin
          scl_q = 1'b1; bus_polls = '0; bus_timer = unit_len();
        end else if (p == 5'd5) begin
          if (bus_polls < bus_cfg.ack_poll_limit && !sd) begin
            ack_q = 1'b1; scl_q = 1'b0; bus_timer = unit_len();
          end else if (bus_polls >= bus_cfg.ack_poll_limit) begin
            ack_q = 1'b0; scl_q = 1'b0; bus_timer = unit_len();
          end else begin
            bus_polls = bus_polls + 8'd1; bus_timer = unit_len(); bus_phase = 5'd5;
          end
        end else begin
          oe_q = 1'b1; seq_finish();
        end
      end
      i2cbm_pkg::OP_READ: begin
        if (p == 5'd0) begin
          oe_q = 1'b0; bus_timer = unit_len();
        end else if (p == 5'd1) begin
          scl_q = 1'b1; bus_shift = {bus_shift[6:0], sd}; bus_timer = unit_len();
        end else if (p == 5'd2) begin
          scl_q = 1'b0; bus_timer = unit_len();
          bus_bits = bus_bits + 4'd1;
          bus_phase = (bus_bits < 4'd8) ? 5'd0 : 5'd3;
        end else begin
          rd_hold = bus_shift; rdv_q = 1'b1; seq_finish();
        end
      end
      default: seq_finish();
    endcase
  endfunction

  function automatic i2cbm_pkg::res_t bus_step(input i2cbm_pkg::op_t c, input logic [7:0] b,
                                               input logic sd);
    i2cbm_pkg::res_t r;
    done_q = 1'b0;
    rdv_q = 1'b0;
    if (bus_op == i2cbm_pkg::OP_IDLE) begin
      if (c >= i2cbm_pkg::OP_START && c <= i2cbm_pkg::OP_NAK) begin
        bus_op = c;
        bus_phase = '0;
        bus_bits = '0;
        bus_polls = '0;
        if (c == i2cbm_pkg::OP_WRITE) bus_shift = b;
        if (c == i2cbm_pkg::OP_READ) bus_shift = '0;
        bus_act(sd);
      end
    end else begin
      if (bus_timer != '0) bus_timer = bus_timer - 16'd1;
      if (bus_timer == '0) begin
        if ((bus_op == i2cbm_pkg::OP_START || bus_op == i2cbm_pkg::OP_STOP) &&
            bus_bits != '0) begin
          bus_bits = bus_bits - 4'd1;
          bus_timer = unit_len();
        end else begin
          bus_act(sd);
        end
      end
    end
    r.pad = 1'b0;
    r.scl_level = scl_q;
    r.sda_level = sda_q;
    r.sda_drive = oe_q;
    r.busy_res = (bus_op != i2cbm_pkg::OP_IDLE);
    r.read_byte = rd_hold;
    r.read_valid = rdv_q;
    r.slave_acked = ack_q;
    r.cmd_done = done_q;
    return r;
  endfunction

  function automatic logic pick_sda(input sda_mode_t m);
    case (m)
      SDA_LOW:  return 1'b0;
      SDA_HIGH: return 1'b1;
      SDA_RAND: return 1'($urandom_range(0, 1));
      default:  return ($urandom_range(0, 7) != 0);
    endcase
  endfunction

  function automatic string fmt_res(input i2cbm_pkg::res_t r);
    return $sformatf("scl %b sda %b oe %b busy %b rd %h rv %b ack %b done %b",
                     r.scl_level, r.sda_level, r.sda_drive, r.busy_res, r.read_byte,
                     r.read_valid, r.slave_acked, r.cmd_done);
  endfunction

  task automatic report_miss(input string what);
    if (n_bad < 10) $display("MISMATCH at %0t: %s", $time, what);
    n_bad++;
  endtask

  task automatic send_req(input i2cbm_pkg::op_t c, input logic [7:0] b, input logic sd);
    i2cbm_pkg::res_t want;
    int              gap;
    logic            was_write;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(100, 400)
                                               : $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tuser <= c;
    in_tdata <= {7'd0, sd, b};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    was_write = (bus_op == i2cbm_pkg::OP_WRITE);
    want = bus_step(c, b, sd);
    if (fixed_pending) begin
      want = i2cbm_pkg::res_t'(fixed_word);
      fixed_pending = 1'b0;
    end
    pin_results_q.push_back(want);
    n_req++;
    if (want.cmd_done) n_done++;
    if (want.read_valid) n_reads++;
    if (want.cmd_done && was_write && want.slave_acked) n_acked++;
  endtask

  // Run one request and tick until the sequencer is idle again.
  task automatic run_cmd(input i2cbm_pkg::op_t c, input logic [7:0] b, input sda_mode_t m);
    i2cbm_pkg::op_t code;
    send_req(c, b, pick_sda(m));
    while (bus_op != i2cbm_pkg::OP_IDLE) begin
      code = i2cbm_pkg::OP_IDLE;
      if (noisy && $urandom_range(0, 11) == 0) code = i2cbm_pkg::op_t'($urandom_range(1, 7));
      send_req(code, 8'($urandom_range(0, 255)), pick_sda(m));
    end
  endtask

  task automatic hold_for_drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (pin_results_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(input i2cbm_pkg::reg_idx_t ri, input logic [15:0] v);
    hold_for_drain();
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= ri;
    cfg_data <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (ri)
      i2cbm_pkg::REG_UNIT_TICKS: bus_cfg.unit_ticks = v;
      i2cbm_pkg::REG_START_STOP: bus_cfg.start_stop_units = v[3:0];
      i2cbm_pkg::REG_ACK_POLL:   bus_cfg.ack_poll_limit = v[7:0];
      default: ;
    endcase
    n_cfg++;
    cfg_valid <= 1'b0;
  endtask

  task automatic run_frame();
    int nw;
    int nr;
    run_cmd(i2cbm_pkg::OP_START, 8'd0, SDA_RAND);
    nw = $urandom_range(1, 3);
    repeat (nw) run_cmd(i2cbm_pkg::OP_WRITE, 8'($urandom_range(0, 255)),
                        sda_mode_t'($urandom_range(0, 3)));
    if ($urandom_range(0, 1) == 1) begin
      run_cmd(i2cbm_pkg::OP_START, 8'd0, SDA_RAND);
      run_cmd(i2cbm_pkg::OP_WRITE, 8'($urandom_range(0, 255)), SDA_RARE_LOW);
      nr = $urandom_range(1, 3);
      for (int k = 0; k < nr; k++) begin
        run_cmd(i2cbm_pkg::OP_READ, 8'd0, SDA_RAND);
        run_cmd((k == nr - 1) ? i2cbm_pkg::OP_NAK : i2cbm_pkg::OP_ACK, 8'd0, SDA_RAND);
      end
    end
    if ($urandom_range(0, 7) != 0) run_cmd(i2cbm_pkg::OP_STOP, 8'd0, SDA_RAND);
  endtask

  // Receiver: ready, light random stalls, or long stalls, switching whenever rx_cycle wraps.
  logic [7:0] rx_cycle = '0;
  logic [1:0] rx_mode = '0;
  int         rx_hold = 0;

  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 8'd1;
    if (rx_cycle == 8'd0) rx_mode <= 2'($urandom_range(0, 2));
    case (rx_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= ($urandom_range(0, 3) != 0);
      default: begin
        if (rx_hold != 0) begin
          rx_hold <= rx_hold - 1;
          out_tready <= 1'b0;
        end else begin
          out_tready <= 1'b1;
          if ($urandom_range(0, 7) == 0) rx_hold <= $urandom_range(1, 16);
        end
      end
    endcase
  end

  i2cbm_pkg::res_t seen, want_r;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      seen = i2cbm_pkg::res_t'(out_tdata);
      n_res++;
      if (pin_results_q.size() == 0) begin
        report_miss($sformatf("unexpected result %h", out_tdata));
      end else begin
        want_r = pin_results_q.pop_front();
        if (seen.scl_level !== want_r.scl_level || seen.sda_level !== want_r.sda_level ||
            seen.sda_drive !== want_r.sda_drive || seen.busy_res !== want_r.busy_res ||
            seen.read_byte !== want_r.read_byte || seen.read_valid !== want_r.read_valid ||
            seen.slave_acked !== want_r.slave_acked || seen.cmd_done !== want_r.cmd_done)
          report_miss($sformatf("result %0d expected %s, got %s",
                                n_res, fmt_res(want_r), fmt_res(seen)));
      end
    end
  end

  initial begin
    #100_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    plan_row_t row;
    int        phase_goal;
    int        pick;
    bus_cfg.unit_ticks = 16'd5;
    bus_cfg.start_stop_units = 4'd3;
    bus_cfg.ack_poll_limit = 8'd50;
    bus_op = i2cbm_pkg::OP_IDLE;
    bus_phase = '0;
    bus_bits = '0;
    bus_shift = '0;
    bus_timer = '0;
    bus_polls = '0;
    scl_q = 1'b1;
    sda_q = 1'b1;
    oe_q = 1'b0;
    ack_q = 1'b0;
    rd_hold = '0;
    done_q = 1'b0;
    rdv_q = 1'b0;
    n_req = 0; n_res = 0; n_bad = 0; n_cfg = 0;
    n_done = 0; n_reads = 0; n_acked = 0;
    burst_left = 0;
    noisy = 1'b0;
    fixed_pending = 1'b0;
    fixed_word = '0;

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < N_PLAN; i++) begin
      row = PLAN[i];
      if (row.is_cfg) begin
        write_reg(row.ri, row.val);
      end else begin
        fixed_pending = row.fixed;
        fixed_word = row.fixed_word;
        run_cmd(row.op, row.val[7:0], row.sdm);
      end
    end

    noisy = 1'b1;
    for (int ph = 0; ph < N_PHASES; ph++) begin
      write_reg(i2cbm_pkg::REG_UNIT_TICKS,
                ($urandom_range(0, 4) == 0) ? 16'($urandom_range(2, 6))
                                            : 16'($urandom_range(0, 1)));
      write_reg(i2cbm_pkg::REG_START_STOP,
                ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 15))
                                            : 16'($urandom_range(0, 3)));
      pick = $urandom_range(0, 5);
      write_reg(i2cbm_pkg::REG_ACK_POLL, (pick == 0) ? 16'd0 : (pick == 1) ? 16'd255
                                                     : 16'($urandom_range(1, 10)));
      phase_goal = (N_ITEMS * (ph + 1)) / N_PHASES;
      while (n_req < phase_goal) begin
        pick = $urandom_range(0, 9);
        if (pick < 7)
          run_frame();
        else if (pick < 9)
          run_cmd(i2cbm_pkg::op_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                  sda_mode_t'($urandom_range(0, 3)));
        else
          hold_for_drain();
      end
    end

    hold_for_drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d requests and checked %0d results across %0d register writes.",
             n_req, n_res, n_cfg);
    $display("Bus commands completed: %0d, byte reads: %0d, slave-acknowledged writes: %0d.",
             n_done, n_reads, n_acked);
    if (n_bad == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", n_bad);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/i2cbm_pkg.sv
hdl/i2cbm_core.sv
hdl/i2cbm_skid.sv
hdl/i2c_byte_master.sv
hdl/i2cbm_checker.sv
sim/testbench.sv
